FILE: src/flow_table_range_match_macros.svh
// Assertion helpers used by the flow table RTL.
`ifndef FLOW_TABLE_RANGE_MATCH_MACROS_SVH
`define FLOW_TABLE_RANGE_MATCH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FTRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FTRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ftrm_pkg.sv
`default_nettype none

package ftrm_pkg;

    localparam int COUNT_W   = 32;
    localparam int ENTRY_W   = 6;
    localparam int DEC_W     = 2;
    localparam int PORT_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int HOME_HIGH_RESET = 1023;

    localparam logic [CFG_IDX_W-1:0] REG_HOME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_HIGH = 2'd1;

    localparam logic [DEC_W-1:0] DEC_HERE  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_PORT1 = 2'd1;
    localparam logic [DEC_W-1:0] DEC_PORT2 = 2'd2;
    localparam logic [DEC_W-1:0] DEC_MISS  = 2'd3;

    localparam logic [PORT_W-1:0] PORT_ONE = 2'd1;
    localparam logic [PORT_W-1:0] PORT_TWO = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c == '1) ? c : c + COUNT_W'(1);
        return r;
    endfunction

    // Drop, local and "no port" all end here; only ports 1 and 2 relay.
    function automatic logic [DEC_W-1:0] action_decision(
        input logic              fwd,
        input logic [PORT_W-1:0] port
    );
        logic [DEC_W-1:0] d;
        d = DEC_HERE;
        if (fwd)
        begin
            unique case (port)
                PORT_ONE: d = DEC_PORT1;
                PORT_TWO: d = DEC_PORT2;
                default:  d = DEC_HERE;
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: src/ftrm_channels.sv
`default_nettype none

interface ftrm_pkt_if #(parameter int ADDR_BITS = 10);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ADDR_BITS-1:0]          dst_ip;
    logic [ADDR_BITS-1:0]          rule_low;
    logic [ADDR_BITS-1:0]          rule_high;
    logic                          rule_forward;
    logic [ftrm_pkg::PORT_W-1:0]   rule_port;

    modport source (output valid, mode, dst_ip, rule_low, rule_high, rule_forward,
                    rule_port, input ready);
    modport sink   (input valid, mode, dst_ip, rule_low, rule_high, rule_forward,
                    rule_port, output ready);
endinterface

interface ftrm_res_if;
    logic                           valid;
    logic                           ready;
    logic [ftrm_pkg::DEC_W-1:0]     decision;
    logic [ftrm_pkg::ENTRY_W-1:0]   matched_entry;
    logic [ftrm_pkg::COUNT_W-1:0]   hit_count;
    logic                           add_rejected;

    modport source (output valid, decision, matched_entry, hit_count, add_rejected,
                    input ready);
    modport sink   (input valid, decision, matched_entry, hit_count, add_rejected,
                    output ready);
endinterface

interface ftrm_cfg_if #(parameter int ADDR_BITS = 10);
    logic                            valid;
    logic                            ready;
    logic [ftrm_pkg::CFG_IDX_W-1:0]  index;
    logic [ADDR_BITS-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/ftrm_ram.sv
`default_nettype none

module ftrm_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 63,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/flow_table_range_match.sv
// A home hit or an empty table goes from accept straight to the done state and then
// into the output register; a walk stops at the first matching rule or after the last.
// Throughput: one item at a time, the walk reading one rule per cycle from the rule
// memory (one read port, one write port).
// Reset: home range 0..1023, home count and rule count cleared; rule memory is not
// cleared, entries past the rule count are never checked.
`default_nettype none
`include "flow_table_range_match_macros.svh"

module flow_table_range_match #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 10
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ftrm_cfg_if.sink    cfg,
    ftrm_pkt_if.sink    pkt,
    ftrm_res_if.source  res
);

    localparam int RULE_SLOTS = TABLE_DEPTH - 1;
    localparam int IW         = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW         = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = ftrm_pkg::COUNT_W;
    localparam int RULE_W     = 2 * ADDR_BITS + 1 + ftrm_pkg::PORT_W;
    localparam int MEM_W      = RULE_W + CNT_W;
    localparam int ENT_W      = ftrm_pkg::ENTRY_W;

    ftrm_pkg::state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]        home_low_reg, home_low_next;
    logic [ADDR_BITS-1:0]        home_high_reg, home_high_next;
    logic [CNT_W-1:0]            home_hits_reg, home_hits_next;
    logic [CW-1:0]               used_reg, used_next;
    logic [CW-1:0]               issue_reg, issue_next;
    logic [CW-1:0]               chk_reg, chk_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [ADDR_BITS-1:0]        dst_reg, dst_next;

    logic [ftrm_pkg::DEC_W-1:0]  res_dec_reg, res_dec_next;
    logic [CW-1:0]               res_ent_reg, res_ent_next;
    logic [CNT_W-1:0]            res_cnt_reg, res_cnt_next;
    logic                        res_rej_reg, res_rej_next;

    logic                        out_vld_reg, out_vld_next;
    logic [ftrm_pkg::DEC_W-1:0]  out_dec_reg, out_dec_next;
    logic [ENT_W-1:0]            out_ent_reg, out_ent_next;
    logic [CNT_W-1:0]            out_cnt_reg, out_cnt_next;
    logic                        out_rej_reg, out_rej_next;

    logic                        accept;
    logic                        full;
    logic                        do_add;
    logic [CW-1:0]               used_after;
    logic                        home_hit;
    logic [CNT_W-1:0]            home_bumped;
    logic                        load_out;
    logic [CW+ENT_W-1:0]         ent_wide;

    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [MEM_W-1:0]            mem_wdata;
    logic [MEM_W-1:0]            mem_rdata;

    logic [ADDR_BITS-1:0]        r_low;
    logic [ADDR_BITS-1:0]        r_high;
    logic                        r_fwd;
    logic [ftrm_pkg::PORT_W-1:0] r_port;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_bumped;
    logic                        r_hit;
    logic                        r_last;

    ftrm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (issue_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    // rule word: low, high, forward, port, hit count
    assign r_low    = mem_rdata[MEM_W-1 -: ADDR_BITS];
    assign r_high   = mem_rdata[MEM_W-1-ADDR_BITS -: ADDR_BITS];
    assign r_fwd    = mem_rdata[CNT_W + ftrm_pkg::PORT_W];
    assign r_port   = mem_rdata[CNT_W +: ftrm_pkg::PORT_W];
    assign r_cnt    = mem_rdata[CNT_W-1:0];
    assign r_bumped = ftrm_pkg::sat_inc(r_cnt);

    assign r_hit  = (state_reg == ftrm_pkg::S_WALK) && chk_vld_reg
                    && (r_low <= dst_reg) && (dst_reg <= r_high);
    assign r_last = (CW'(chk_reg + CW'(1)) == used_reg);

    assign pkt.ready  = (state_reg == ftrm_pkg::S_IDLE);
    assign cfg.ready  = 1'b1;
    assign accept     = pkt.valid && pkt.ready;
    assign full       = (used_reg == CW'(RULE_SLOTS));
    assign do_add     = accept && pkt.mode && !full;
    assign used_after = do_add ? CW'(used_reg + CW'(1)) : used_reg;
    assign home_hit   = (home_low_reg <= pkt.dst_ip) && (pkt.dst_ip <= home_high_reg);
    assign home_bumped = ftrm_pkg::sat_inc(home_hits_reg);

    // New rule goes in at accept; a hit writes back its bumped count.
    assign mem_we    = do_add || r_hit;
    assign mem_waddr = do_add ? used_reg[IW-1:0] : chk_reg[IW-1:0];
    assign mem_wdata = do_add
                     ? {pkt.rule_low, pkt.rule_high, pkt.rule_forward, pkt.rule_port,
                        CNT_W'(0)}
                     : {mem_rdata[MEM_W-1:CNT_W], r_bumped};

    assign load_out = (state_reg == ftrm_pkg::S_DONE) && (!out_vld_reg || res.ready);
    assign ent_wide = (CW+ENT_W)'(res_ent_reg);

    always_comb
    begin
        home_low_next  = home_low_reg;
        home_high_next = home_high_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ftrm_pkg::REG_HOME_LOW:  home_low_next  = cfg.data;
                ftrm_pkg::REG_HOME_HIGH: home_high_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        home_hits_next = home_hits_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        chk_next       = chk_reg;
        chk_vld_next   = chk_vld_reg;
        dst_next       = dst_reg;
        res_dec_next   = res_dec_reg;
        res_ent_next   = res_ent_reg;
        res_cnt_next   = res_cnt_reg;
        res_rej_next   = res_rej_reg;

        unique case (state_reg)
            ftrm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    dst_next     = pkt.dst_ip;
                    res_rej_next = pkt.mode && full;
                    used_next    = used_after;
                    issue_next   = '0;
                    chk_vld_next = 1'b0;
                    if (home_hit)
                    begin
                        home_hits_next = home_bumped;
                        res_dec_next   = ftrm_pkg::DEC_HERE;
                        res_ent_next   = '0;
                        res_cnt_next   = home_bumped;
                        state_next     = ftrm_pkg::S_DONE;
                    end
                    else if (used_after == '0)
                    begin
                        res_dec_next = ftrm_pkg::DEC_MISS;
                        res_ent_next = '0;
                        res_cnt_next = '0;
                        state_next   = ftrm_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ftrm_pkg::S_WALK;
                    end
                end
            end

            ftrm_pkg::S_WALK:
            begin
                if (issue_reg != used_reg)
                begin
                    issue_next   = CW'(issue_reg + CW'(1));
                    chk_next     = issue_reg;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (r_hit)
                begin
                    res_dec_next = ftrm_pkg::action_decision(r_fwd, r_port);
                    res_ent_next = CW'(chk_reg + CW'(1));
                    res_cnt_next = r_bumped;
                    chk_vld_next = 1'b0;
                    state_next   = ftrm_pkg::S_DONE;
                end
                else if (chk_vld_reg && r_last)
                begin
                    res_dec_next = ftrm_pkg::DEC_MISS;
                    res_ent_next = '0;
                    res_cnt_next = '0;
                    chk_vld_next = 1'b0;
                    state_next   = ftrm_pkg::S_DONE;
                end
            end

            ftrm_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    state_next = ftrm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ftrm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_dec_next = out_dec_reg;
        out_ent_next = out_ent_reg;
        out_cnt_next = out_cnt_reg;
        out_rej_next = out_rej_reg;
        out_vld_next = out_vld_reg && !res.ready;
        if (load_out)
        begin
            out_vld_next = 1'b1;
            out_dec_next = res_dec_reg;
            out_ent_next = ent_wide[ENT_W-1:0];
            out_cnt_next = res_cnt_reg;
            out_rej_next = res_rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftrm_pkg::S_IDLE;
            home_low_reg  <= '0;
            home_high_reg <= ADDR_BITS'(ftrm_pkg::HOME_HIGH_RESET);
            home_hits_reg <= '0;
            used_reg      <= '0;
            issue_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            home_low_reg  <= home_low_next;
            home_high_reg <= home_high_next;
            home_hits_reg <= home_hits_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            chk_vld_reg   <= chk_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg     <= chk_next;
        dst_reg     <= dst_next;
        res_dec_reg <= res_dec_next;
        res_ent_reg <= res_ent_next;
        res_cnt_reg <= res_cnt_next;
        res_rej_reg <= res_rej_next;
        out_dec_reg <= out_dec_next;
        out_ent_reg <= out_ent_next;
        out_cnt_reg <= out_cnt_next;
        out_rej_reg <= out_rej_next;
    end

    assign res.valid         = out_vld_reg;
    assign res.decision      = out_dec_reg;
    assign res.matched_entry = out_ent_reg;
    assign res.hit_count     = out_cnt_reg;
    assign res.add_rejected  = out_rej_reg;

    `FTRM_ASSERT_NOW(a_chk_in_range, chk_vld_reg, chk_reg < used_reg,
        "rule check beyond stored rule count")
    `FTRM_ASSERT_NEXT(a_add_grows, do_add, used_reg == CW'($past(used_reg) + CW'(1)),
        "accepted add did not grow the rule count")
    `FTRM_ASSERT_NEXT(a_home_monotonic, 1'b1, home_hits_reg >= $past(home_hits_reg),
        "home hit count went down")
    `FTRM_ASSERT_NOW(a_miss_clean, res.valid && (res.decision == ftrm_pkg::DEC_MISS),
        (res.matched_entry == '0) && (res.hit_count == '0),
        "miss result carries entry or count")

endmodule

`default_nettype wire

FILE: tb/sv/ftrm_tb_pkg.sv
`timescale 1ns / 100ps

package ftrm_tb_pkg;

    localparam int FT_DEPTH   = 64;
    localparam int FT_ADDR_W  = 10;
    localparam int RULE_SLOTS = FT_DEPTH - 1;
    localparam int ADDR_MAX   = (1 << FT_ADDR_W) - 1;

    typedef logic [FT_ADDR_W-1:0] addr_t;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_ADD    = 1'b1;

    localparam logic ACT_DROP = 1'b0;
    localparam logic ACT_FWD  = 1'b1;

    localparam logic [ftrm_pkg::PORT_W-1:0] PORT_NONE  = 2'd0;
    localparam logic [ftrm_pkg::PORT_W-1:0] PORT_LOCAL = 2'd3;

    // index with no register behind it; writes must be ignored
    localparam logic [ftrm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                          mode;
        addr_t                         dst;
        addr_t                         lo;
        addr_t                         hi;
        logic                          fwd;
        logic [ftrm_pkg::PORT_W-1:0]   port;
    } pkt_beat_t;

endpackage

FILE: tb/sv/ftrm_match_checker.sv
`timescale 1ns / 100ps

module ftrm_match_checker (
    input  logic        clk,
    input  logic        rst_n,
    ftrm_cfg_if         cfg,
    ftrm_pkt_if         pkt,
    ftrm_res_if         res,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned miss_count,
    output int unsigned reject_count
);
    import ftrm_pkg::*;
    import ftrm_tb_pkg::*;

    typedef struct packed {
        logic [DEC_W-1:0]   decision;
        logic [ENTRY_W-1:0] entry;
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } match_res_t;

    typedef struct packed {
        addr_t             lo;
        addr_t             hi;
        logic              fwd;
        logic [PORT_W-1:0] port;
    } rule_t;

    addr_t              home_lo;
    addr_t              home_hi;
    rule_t              rules [RULE_SLOTS];
    logic [COUNT_W-1:0] rule_hits [RULE_SLOTS];
    logic [COUNT_W-1:0] home_hits;
    int unsigned        n_rules;
    match_res_t         matches_due [$];
    int unsigned        fails;
    int unsigned        misses;
    int unsigned        rejects;

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want_v,
                               input logic [COUNT_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        match_res_t want;
        match_res_t got;
        rule_t      cand;
        logic       found;
        if (!rst_n)
        begin
            home_lo   = '0;
            home_hi   = addr_t'(HOME_HIGH_RESET);
            home_hits = '0;
            n_rules   = 0;
            fails     = 0;
            misses    = 0;
            rejects   = 0;
            matches_due.delete();
        end
        else
        begin
            // a result beat can only belong to an item taken at an earlier edge
            if (res.valid && res.ready)
            begin
                got = '{res.decision, res.matched_entry, res.hit_count, res.add_rejected};
                if (matches_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result beat with nothing expected, got dec %0d entry %0d",
                             $time, got.decision, got.entry);
                end
                else
                begin
                    want = matches_due.pop_front();
                    check_field("decision", COUNT_W'(want.decision), COUNT_W'(got.decision));
                    check_field("matched_entry", COUNT_W'(want.entry), COUNT_W'(got.entry));
                    check_field("hit_count", want.count, got.count);
                    check_field("add_rejected", COUNT_W'(want.rejected),
                                COUNT_W'(got.rejected));
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_HOME_LOW:  home_lo = cfg.data;
                    REG_HOME_HIGH: home_hi = cfg.data;
                    default: ;
                endcase
            end

            if (pkt.valid && pkt.ready)
            begin
                want  = '{DEC_MISS, '0, '0, 1'b0};
                found = 1'b0;
                if (pkt.mode == MODE_ADD)
                begin
                    if (n_rules < RULE_SLOTS)
                    begin
                        rules[n_rules]     = '{pkt.rule_low, pkt.rule_high, pkt.rule_forward,
                                               pkt.rule_port};
                        rule_hits[n_rules] = '0;
                        n_rules++;
                    end
                    else
                    begin
                        want.rejected = 1'b1;
                        rejects++;
                    end
                end

                if (home_lo <= pkt.dst_ip && pkt.dst_ip <= home_hi)
                begin
                    if (home_hits != '1)
                        home_hits++;
                    want.decision = DEC_HERE;
                    want.count    = home_hits;
                end
                else
                begin
                    // first match in table order decides
                    for (int i = 0; i < n_rules && !found; i++)
                    begin
                        cand = rules[i];
                        if (cand.lo <= pkt.dst_ip && pkt.dst_ip <= cand.hi)
                        begin
                            found = 1'b1;
                            if (rule_hits[i] != '1)
                                rule_hits[i]++;
                            want.entry = ENTRY_W'(i + 1);
                            want.count = rule_hits[i];
                            if (cand.fwd == ACT_FWD && cand.port == PORT_ONE)
                                want.decision = DEC_PORT1;
                            else if (cand.fwd == ACT_FWD && cand.port == PORT_TWO)
                                want.decision = DEC_PORT2;
                            else
                                want.decision = DEC_HERE;
                        end
                    end
                    if (!found)
                        misses++;
                end
                matches_due.push_back(want);
            end
        end
        fail_count   <= fails;
        pending      <= matches_due.size();
        miss_count   <= misses;
        reject_count <= rejects;
    end

endmodule

FILE: tb/sv/flow_table_range_match_tb.sv
`timescale 1ns / 100ps

module flow_table_range_match_tb;
    import ftrm_pkg::*;
    import ftrm_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 2 * FT_DEPTH + 8;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 5;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        idle_on = 1'b1;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned miss_count;
    int unsigned reject_count;
    int unsigned n_sent;
    int unsigned n_adds;
    int unsigned n_writes;
    int unsigned cycle_count;
    addr_t       cur_lo = '0;
    addr_t       cur_hi = '1;
    addr_t       span_lo [$];
    addr_t       span_hi [$];

    ftrm_cfg_if #(.ADDR_BITS(FT_ADDR_W)) cfg_ch ();
    ftrm_pkt_if #(.ADDR_BITS(FT_ADDR_W)) pkt_ch ();
    ftrm_res_if                          res_ch ();

    flow_table_range_match #(
        .TABLE_DEPTH (FT_DEPTH),
        .ADDR_BITS   (FT_ADDR_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pkt   (pkt_ch),
        .res   (res_ch)
    );

    ftrm_match_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .pkt          (pkt_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .miss_count   (miss_count),
        .reject_count (reject_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic addr_t clip_add(input addr_t base, input int unsigned span);
        int unsigned sum;
        sum = base + span;
        return (sum > ADDR_MAX) ? addr_t'(ADDR_MAX) : addr_t'(sum);
    endfunction

    function automatic pkt_beat_t beat_of(input logic mode, input int unsigned dst,
                                          input int unsigned lo, input int unsigned hi,
                                          input logic fwd, input logic [PORT_W-1:0] port);
        pkt_beat_t b;
        b = '{mode, addr_t'(dst), addr_t'(lo), addr_t'(hi), fwd, port};
        return b;
    endfunction

    // narrow rules keep walks long; some wide, empty and fully random ones
    function automatic pkt_beat_t random_beat(input int unsigned add_pct);
        pkt_beat_t   b;
        int unsigned pick;
        int unsigned k;
        b.mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_LOOKUP;
        b.lo   = addr_t'($urandom);
        b.hi   = addr_t'($urandom);
        b.fwd  = 1'($urandom);
        b.port = PORT_W'($urandom);
        if (b.mode == MODE_ADD)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                b.hi = clip_add(b.lo, $urandom_range(0, 31));
            else if (pick < 85)
            begin
                b.lo = addr_t'($urandom_range(1, ADDR_MAX));
                b.hi = addr_t'($urandom_range(0, b.lo - 1));
            end
        end
        pick = $urandom_range(99);
        if (pick < 50 && span_lo.size() > 0)
        begin
            k = $urandom_range(0, span_lo.size() - 1);
            if (span_lo[k] <= span_hi[k])
                b.dst = addr_t'(span_lo[k] + $urandom_range(0, span_hi[k] - span_lo[k]));
            else
                b.dst = span_lo[k];
        end
        else if (pick < 65)
            b.dst = clip_add(cur_lo, $urandom_range(0, 15));
        else
            b.dst = addr_t'($urandom);
        return b;
    endfunction

    task automatic put_fields(input pkt_beat_t b);
        pkt_ch.mode         <= b.mode;
        pkt_ch.dst_ip       <= b.dst;
        pkt_ch.rule_low     <= b.lo;
        pkt_ch.rule_high    <= b.hi;
        pkt_ch.rule_forward <= b.fwd;
        pkt_ch.rule_port    <= b.port;
    endtask

    task automatic send_beat(input pkt_beat_t b);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            pkt_ch.valid <= 1'b0;
            put_fields(random_beat(50));
            @(posedge clk);
        end
        pkt_ch.valid <= 1'b1;
        put_fields(b);
        do
        begin
            @(posedge clk);
        end
        while (!pkt_ch.ready);
        n_sent++;
        if (b.mode == MODE_ADD)
        begin
            n_adds++;
            span_lo.push_back(b.lo);
            span_hi.push_back(b.hi);
        end
    endtask

    // checker count is registered, so always step the clock before reading it
    task automatic drain();
        pkt_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input addr_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        n_writes++;
    endtask

    task automatic program_home(input addr_t lo, input addr_t hi);
        drain();
        write_reg(REG_HOME_LOW, lo);
        write_reg(REG_HOME_HIGH, hi);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned phase_len [PHASES];
        addr_t       lo;
        addr_t       hi;
        phase_len = '{300, 300, 100, 300, 300};
        pkt_ch.valid <= 1'b0;
        put_fields(beat_of(MODE_LOOKUP, 0, 0, 0, ACT_DROP, PORT_NONE));
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_HOME_LOW;
        cfg_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset home range covers every address, even after an add
        send_beat(beat_of(MODE_LOOKUP, 0, ADDR_MAX, ADDR_MAX, ACT_FWD, PORT_LOCAL));
        send_beat(beat_of(MODE_LOOKUP, ADDR_MAX, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_ADD, 150, 100, 200, ACT_FWD, PORT_ONE));

        // empty home range: everything goes through the rules
        program_home('1, '0);
        write_reg(REG_SPARE, '1);
        send_beat(beat_of(MODE_LOOKUP, 150, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, 50, ADDR_MAX, 0, ACT_FWD, PORT_TWO));
        send_beat(beat_of(MODE_ADD, 0, 0, 0, ACT_DROP, PORT_ONE));
        send_beat(beat_of(MODE_ADD, ADDR_MAX, ADDR_MAX, ADDR_MAX, ACT_FWD, PORT_TWO));
        send_beat(beat_of(MODE_ADD, 350, 300, 400, ACT_FWD, PORT_LOCAL));
        send_beat(beat_of(MODE_ADD, 550, 500, 600, ACT_FWD, PORT_NONE));
        send_beat(beat_of(MODE_ADD, 650, 700, 600, ACT_FWD, PORT_ONE));
        send_beat(beat_of(MODE_LOOKUP, 700, 0, ADDR_MAX, ACT_FWD, PORT_ONE));
        send_beat(beat_of(MODE_ADD, 130, 120, 180, ACT_FWD, PORT_TWO));
        send_beat(beat_of(MODE_LOOKUP, 200, ADDR_MAX, ADDR_MAX, ACT_FWD, PORT_TWO));
        send_beat(beat_of(MODE_ADD, 950, 900, 1022, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, 1022, 0, 0, ACT_DROP, PORT_NONE));

        program_home(10'd1000, 10'd1010);
        send_beat(beat_of(MODE_LOOKUP, 1000, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, 1010, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, 1011, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, ADDR_MAX, 0, 0, ACT_DROP, PORT_NONE));

        program_home(10'd512, 10'd512);
        send_beat(beat_of(MODE_LOOKUP, 512, 0, 0, ACT_DROP, PORT_NONE));
        send_beat(beat_of(MODE_LOOKUP, 511, 0, 0, ACT_DROP, PORT_NONE));

        // random phases; the table fills early on, later adds hit the full case
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lo = 10'd20;
                    hi = 10'd40;
                end
                1:
                begin
                    lo = addr_t'($urandom);
                    hi = clip_add(lo, $urandom_range(0, 63));
                end
                2:
                begin
                    lo = '0;
                    hi = '1;
                end
                3:
                begin
                    lo = 10'd600;
                    hi = 10'd100;
                end
                default:
                begin
                    lo = addr_t'($urandom);
                    hi = addr_t'($urandom);
                end
            endcase
            program_home(lo, hi);
            if (p == 3)
                idle_on <= 1'b0;
            for (int k = 0; k < phase_len[p]; k++)
            begin
                if (p == 1 && k == 40)
                    hold_req <= 1'b1;
                if (p == 3 && k == 150)
                    drain();
                send_beat(random_beat((p == 0) ? 20 : 10));
            end
            if (p == 3)
                idle_on <= 1'b1;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d packet beats, %0d rule adds (%0d refused on a full table), %0d reg writes",
                 n_sent, n_adds, reject_count, n_writes);
        $display("%0d lookups missed every range; home range swept through empty, full, narrow",
                 miss_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
